[src/rbd_pkg.sv]
// shared opcodes and control types for the ring buffer deque
package rbd_pkg;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} rbd_op_t;

	// one command word broadcast to every cell in the row
	typedef struct packed {
		logic shift_up;   // push front: every entry moves one cell toward the back
		logic shift_down; // pop front: every entry moves one cell toward the front
		logic fill;       // push back: first free cell takes the word
		logic trim;       // pop back: last occupied cell lets go
	} rbd_ctrl_t;

endpackage

[src/ring_buffer_deque.sv]
// a result is registered and appears in the cycle after its item is accepted
// throughput: one item per cycle while in_stall is low; the whole row of cells shifts or loads at once
// in_stall follows out_stall while a result is held in the output register
// reset clears every cell's occupied bit, the entry count and the output valid;
// stored words are not reset and are never read before a push writes them
module ring_buffer_deque
	import rbd_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] data_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pop_value,
	output logic               was_empty,
	output logic               was_full,
	output logic [4:0]         occupancy
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]      cell_occ;
	logic [DEPTH-1:0]      cell_last;

	logic [DATA_WIDTH-1:0] push_word;
	logic [DATA_WIDTH-1:0] back_word;
	logic [DATA_WIDTH-1:0] popped;
	logic                  accept;
	logic                  is_push;
	logic                  full;
	logic                  empty;
	logic                  push_ok;
	logic                  pop_ok;
	rbd_ctrl_t             ctrl;
	rbd_op_t               op;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_next;

	logic                  out_valid_q;
	logic signed [31:0]    pop_value_q;
	logic                  was_empty_q;
	logic                  was_full_q;
	logic [4:0]            occupancy_q;

	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign op        = rbd_op_t'(opcode);
	assign push_word = DATA_WIDTH'($unsigned(data_in));

	assign full    = cell_occ[DEPTH-1];
	assign empty   = !cell_occ[0];
	assign is_push = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
	assign push_ok = is_push && !full;
	assign pop_ok  = !is_push && !empty;

	always_comb begin
		ctrl            = '0;
		ctrl.shift_up   = accept && push_ok && (op == OP_PUSH_FRONT);
		ctrl.fill       = accept && push_ok && (op == OP_PUSH_BACK);
		ctrl.shift_down = accept && pop_ok && (op == OP_POP_FRONT);
		ctrl.trim       = accept && pop_ok && (op == OP_POP_BACK);
	end

	// the back entry is the one cell flagged last, so an and-or select picks it
	always_comb begin
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_word = back_word | (cell_data[i] & {DATA_WIDTH{cell_last[i]}});
		end
	end

	always_comb begin
		popped = '0;
		if (pop_ok) begin
			popped = (op == OP_POP_FRONT) ? cell_data[0] : back_word;
		end
	end

	always_comb begin
		count_next = count_q;
		if (push_ok) begin
			count_next = count_q + CW'(1);
		end else if (pop_ok) begin
			count_next = count_q - CW'(1);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_data;
		logic                  prev_occ;
		logic [DATA_WIDTH-1:0] next_data;
		logic                  next_occ;

		// front end of the row sees the incoming word as an always occupied neighbor
		if (i == 0) begin : g_head
			assign prev_data = push_word;
			assign prev_occ  = 1'b1;
		end else begin : g_body
			assign prev_data = cell_data[i-1];
			assign prev_occ  = cell_occ[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_data = '0;
			assign next_occ  = 1'b0;
		end else begin : g_inner
			assign next_data = cell_data[i+1];
			assign next_occ  = cell_occ[i+1];
		end

		rbd_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.push_word(push_word),
			.prev_data(prev_data),
			.prev_occ (prev_occ),
			.next_data(next_data),
			.next_occ (next_occ),
			.data_q   (cell_data[i]),
			.occ_q    (cell_occ[i]),
			.last     (cell_last[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_value_q <= 32'($unsigned(popped));
			was_empty_q <= !is_push && empty;
			was_full_q  <= is_push && full;
			occupancy_q <= 5'(count_next);
		end
	end

	assign out_valid = out_valid_q;
	assign pop_value = pop_value_q;
	assign was_empty = was_empty_q;
	assign was_full  = was_full_q;
	assign occupancy = occupancy_q;

endmodule

[src/rbd_cell.sv]
// one storage cell of the deque row, exchanging its word with both neighbors
module rbd_cell
	import rbd_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rbd_ctrl_t             ctrl,
	input  logic [DATA_WIDTH-1:0] push_word,
	input  logic [DATA_WIDTH-1:0] prev_data,
	input  logic                  prev_occ,
	input  logic [DATA_WIDTH-1:0] next_data,
	input  logic                  next_occ,
	output logic [DATA_WIDTH-1:0] data_q,
	output logic                  occ_q,
	output logic                  last
);

	logic take_fill;
	logic take_trim;

	// the free cell right behind the last occupied one
	assign take_fill = ctrl.fill && !occ_q && prev_occ;
	assign take_trim = ctrl.trim && occ_q && !next_occ;
	assign last      = occ_q && !next_occ;

	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			data_q <= prev_data;
		end else if (ctrl.shift_down) begin
			data_q <= next_data;
		end else if (take_fill) begin
			data_q <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.shift_up) begin
			occ_q <= prev_occ;
		end else if (ctrl.shift_down) begin
			occ_q <= next_occ;
		end else if (take_fill) begin
			occ_q <= 1'b1;
		end else if (take_trim) begin
			occ_q <= 1'b0;
		end
	end

endmodule

[src/rbd_checker.sv]
// port-level checks for the ring buffer deque, bound to the top level
module rbd_checker #(
	parameter int DEPTH = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] pop_value,
	input logic               was_empty,
	input logic               was_full,
	input logic [4:0]         occupancy
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pop_value) && $stable(occupancy))
		else $error("stalled result changed");

	// every accepted item shows its result on the next cycle
	a_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted item produced no result");

	// a push and a pop cannot both have failed
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(was_empty && was_full))
		else $error("empty and full flagged together");

	// a refused pop leaves nothing held and returns zero
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_empty |-> pop_value == 32'sd0 && occupancy == 5'd0)
		else $error("refused pop reported data or entries");

	// a dropped push means the deque is at capacity
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_full |-> occupancy == 5'(DEPTH) && pop_value == 32'sd0)
		else $error("dropped push without full occupancy");

endmodule

bind ring_buffer_deque rbd_checker #(.DEPTH(DEPTH)) u_rbd_checker (.*);
